@@ rtl/udptun_pkg.sv @@
// Shared types and constants for the UDP/IPv4 tunnel encap/decap block.
`timescale 1ns / 1ps
package udptun_pkg;

	localparam int unsigned QUEUE_DEPTH_DEF = 4;

	localparam logic [2:0] REG_SOURCE_ADDRESS = 3'd0;
	localparam logic [2:0] REG_DEST_ADDRESS = 3'd1;
	localparam logic [2:0] REG_SOURCE_PORT = 3'd2;
	localparam logic [2:0] REG_DEST_PORT = 3'd3;
	localparam logic [2:0] REG_USE_DEST_ANNOT = 3'd4;
	localparam logic [2:0] REG_UDP_CSUM_EN = 3'd5;

	localparam logic CMD_ENCAP = 1'b0;
	localparam logic CMD_DECAP = 1'b1;

	localparam logic PORT_HEADER = 1'b0;
	localparam logic PORT_DECAP = 1'b1;

	localparam logic [16:0] MAX_PAYLOAD_BYTES = 17'd65507;
	localparam logic [16:0] BYTE_COUNT_MAX = 17'h1FFFF;
	localparam logic [16:0] TUNNEL_HDR_BYTES = 17'd28;
	localparam logic [16:0] UDP_HDR_BYTES = 17'd8;
	localparam logic [7:0] IPV4_TTL = 8'd250;
	localparam logic [7:0] IPV4_PROTO_UDP = 8'd17;
	localparam logic [15:0] IPV4_VER_IHL_TOS = 16'h4500;

	// header word positions
	localparam logic [2:0] HW_LEN = 3'd0;
	localparam logic [2:0] HW_IDENT = 3'd1;
	localparam logic [2:0] HW_PROTO = 3'd2;
	localparam logic [2:0] HW_SRC = 3'd3;
	localparam logic [2:0] HW_DST = 3'd4;
	localparam logic [2:0] HW_PORTS = 3'd5;
	localparam logic [2:0] HW_UDP = 3'd6;

	typedef struct packed {
		logic [31:0] source_address;
		logic [31:0] dest_address;
		logic [15:0] source_port;
		logic [15:0] dest_port;
		logic        use_dest_annotation;
		logic        udp_checksum_enable;
	} cfg_t;

	// one queued job: a decap word to pass on, or an encap header to build
	typedef struct packed {
		logic        cmd;
		logic [31:0] word;   // decap data word, or destination address for encap
		logic        last;
		logic [2:0]  nb;
		logic [16:0] bytes;
		logic [31:0] sum;
		logic [15:0] ident;
		logic [15:0] dport;
	} job_t;

endpackage

@@ rtl/udptun_front.sv @@
// Front end: accepts packet words, keeps payload sum/count and decap position, queues jobs.
`timescale 1ns / 1ps
module udptun_front (
	input  logic               clk,
	input  logic               arst_n,
	input  udptun_pkg::cfg_t   cfg,
	input  logic               clr_learn,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               command,
	input  logic [31:0]        data_word,
	input  logic               last_word,
	input  logic [2:0]         bytes_valid,
	input  logic [31:0]        annotated_dest,
	input  logic               q_full,
	output logic               q_push,
	output udptun_pkg::job_t   q_data
);
	import udptun_pkg::*;

	localparam logic [2:0] IDX_LEARN = 3'd5;
	localparam logic [2:0] IDX_PASS = 3'd7;

	logic [15:0] ip_ident_q;
	logic [15:0] learned_port_q;
	logic [16:0] payload_bytes_q;
	logic [31:0] payload_sum_q;
	logic [2:0]  decap_idx_q;

	logic        acc;
	logic [2:0]  nb_eff;
	logic [31:0] masked;
	logic [16:0] half_sum;
	logic [32:0] sum_ext;
	logic [31:0] sum_next;
	logic [17:0] bytes_ext;
	logic [16:0] bytes_next;
	logic [15:0] dport;

	assign in_ready = !q_full;
	assign acc = in_valid && in_ready;

	always_comb begin
		nb_eff = 3'd4;
		if (last_word && bytes_valid >= 3'd1 && bytes_valid <= 3'd3) begin
			nb_eff = bytes_valid;
		end
		case (nb_eff)
			3'd1: masked = data_word & 32'hFF00_0000;
			3'd2: masked = data_word & 32'hFFFF_0000;
			3'd3: masked = data_word & 32'hFFFF_FF00;
			default: masked = data_word;
		endcase
	end

	assign half_sum = {1'b0, masked[31:16]} + {1'b0, masked[15:0]};
	assign sum_ext = {1'b0, payload_sum_q} + {16'b0, half_sum};
	assign sum_next = sum_ext[31:0] + {31'b0, sum_ext[32]};
	assign bytes_ext = {1'b0, payload_bytes_q} + {15'b0, nb_eff};
	assign bytes_next = bytes_ext[17] ? BYTE_COUNT_MAX : bytes_ext[16:0];
	assign dport = (cfg.dest_port != 16'd0) ? cfg.dest_port : learned_port_q;

	assign q_push = acc && ((command == CMD_DECAP && decap_idx_q == IDX_PASS) ||
		(command == CMD_ENCAP && last_word));

	always_comb begin
		q_data.cmd = command;
		q_data.word = (command == CMD_DECAP) ? data_word :
			(cfg.use_dest_annotation ? annotated_dest : cfg.dest_address);
		q_data.last = last_word;
		q_data.nb = nb_eff;
		q_data.bytes = bytes_next;
		q_data.sum = sum_next;
		q_data.ident = ip_ident_q;
		q_data.dport = dport;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ip_ident_q <= '0;
			learned_port_q <= '0;
			payload_bytes_q <= '0;
			payload_sum_q <= '0;
			decap_idx_q <= '0;
		end else begin
			if (clr_learn) begin
				learned_port_q <= '0;
			end else if (acc && command == CMD_DECAP && decap_idx_q == IDX_LEARN &&
				cfg.dest_port == 16'd0 && learned_port_q == 16'd0) begin
				learned_port_q <= data_word[31:16];
			end
			if (acc && command == CMD_DECAP) begin
				if (last_word) begin
					decap_idx_q <= '0;
				end else if (decap_idx_q != IDX_PASS) begin
					decap_idx_q <= decap_idx_q + 3'd1;
				end
			end
			if (acc && command == CMD_ENCAP) begin
				if (last_word) begin
					payload_bytes_q <= '0;
					payload_sum_q <= '0;
					ip_ident_q <= ip_ident_q + 16'd1;
				end else begin
					payload_bytes_q <= bytes_next;
					payload_sum_q <= sum_next;
				end
			end
		end
	end

	a_encap_clear: assert property (@(posedge clk) disable iff (!arst_n)
		acc && command == CMD_ENCAP && last_word |=>
		payload_bytes_q == 17'd0 && payload_sum_q == 32'd0)
		else $error("payload totals not cleared after packet end");
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("job pushed into full queue");
	a_idx_adv: assert property (@(posedge clk) disable iff (!arst_n)
		acc && command == CMD_DECAP && !last_word |=> decap_idx_q != 3'd0)
		else $error("decap position failed to advance");
	a_learn_clr: assert property (@(posedge clk) disable iff (!arst_n)
		clr_learn |=> learned_port_q == 16'd0)
		else $error("learned port not cleared on dest_port write");

endmodule

@@ rtl/udptun_queue.sv @@
// Job queue between the front end and the header/stream back end.
`timescale 1ns / 1ps
module udptun_queue #(
	parameter int unsigned DEPTH = udptun_pkg::QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  udptun_pkg::job_t push_data,
	output logic             full,
	input  logic             pop,
	output logic             empty,
	output udptun_pkg::job_t head
);
	import udptun_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	job_t             entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full = (count_q == CNT_FULL);
	assign empty = (count_q == '0);
	assign head = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("queue underflow");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_FULL)
		else $error("queue count out of range");

endmodule

@@ rtl/udptun_back.sv @@
// Back end: builds the seven header words with checksums, passes decap words, output register.
`timescale 1ns / 1ps
module udptun_back (
	input  logic             clk,
	input  logic             arst_n,
	input  udptun_pkg::cfg_t cfg,
	input  logic             q_empty,
	input  udptun_pkg::job_t q_head,
	output logic             q_pop,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [31:0]      out_word,
	output logic             out_last,
	output logic [2:0]       out_bytes_valid,
	output logic             out_port,
	output logic             oversize
);
	import udptun_pkg::*;

	localparam logic [16:0] IP_CONST_SUM = {1'b0, IPV4_VER_IHL_TOS} + {1'b0, IPV4_TTL, IPV4_PROTO_UDP};

	logic        job_valid_s1;
	job_t        job_s1;
	logic [2:0]  k_q;
	logic [15:0] tot_len_s1;
	logic [15:0] udp_len_s1;
	logic        over_s1;
	logic [18:0] ip_acc_q;
	logic [19:0] udp_acc_q;

	logic        out_valid_q;
	logic [31:0] out_word_q;
	logic        out_last_q;
	logic [2:0]  out_nb_q;
	logic        out_port_q;
	logic        oversize_q;

	logic        out_load;
	logic        emit;
	logic        job_done;
	logic [16:0] tot_ext;
	logic [16:0] udp_ext;
	logic [16:0] ip_fold2;
	logic [15:0] ip_csum;
	logic [15:0] udp_c;
	logic [15:0] udp_field;
	logic [31:0] word_c;
	logic        last_c;
	logic [2:0]  nb_c;
	logic        port_c;
	logic        over_c;

	assign out_load = !out_valid_q || out_ready;
	assign emit = job_valid_s1 && out_load;
	assign job_done = emit && (job_s1.cmd == CMD_DECAP || k_q == HW_UDP);
	assign q_pop = !q_empty && (!job_valid_s1 || job_done);

	assign tot_ext = q_head.bytes + TUNNEL_HDR_BYTES;
	assign udp_ext = q_head.bytes + UDP_HDR_BYTES;

	assign ip_fold2 = {1'b0, ip_acc_q[15:0]} + {16'b0, ip_acc_q[16]};
	assign ip_csum = ~ip_fold2[15:0];
	assign udp_c = ~udp_acc_q[15:0];
	assign udp_field = !cfg.udp_checksum_enable ? 16'h0000 :
		((udp_c == 16'h0000) ? 16'hFFFF : udp_c);

	always_comb begin
		last_c = 1'b0;
		nb_c = 3'd4;
		port_c = PORT_HEADER;
		over_c = over_s1;
		case (k_q)
			HW_LEN: word_c = {IPV4_VER_IHL_TOS, tot_len_s1};
			HW_IDENT: word_c = {job_s1.ident, 16'h0000};
			HW_PROTO: word_c = {IPV4_TTL, IPV4_PROTO_UDP, ip_csum};
			HW_SRC: word_c = cfg.source_address;
			HW_DST: word_c = job_s1.word;
			HW_PORTS: word_c = {cfg.source_port, job_s1.dport};
			HW_UDP: begin
				word_c = {udp_len_s1, udp_field};
				last_c = 1'b1;
			end
			default: word_c = job_s1.word;
		endcase
		if (job_s1.cmd == CMD_DECAP) begin
			word_c = job_s1.word;
			last_c = job_s1.last;
			nb_c = job_s1.nb;
			port_c = PORT_DECAP;
			over_c = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			job_s1 <= q_head;
			tot_len_s1 <= tot_ext[15:0];
			udp_len_s1 <= udp_ext[15:0];
			over_s1 <= (q_head.bytes > MAX_PAYLOAD_BYTES);
			ip_acc_q <= {2'b0, IP_CONST_SUM} + {3'b0, q_head.ident} +
				{3'b0, q_head.word[31:16]} + {3'b0, q_head.word[15:0]};
			udp_acc_q <= {4'b0, q_head.sum[31:16]} + {4'b0, q_head.sum[15:0]} +
				{4'b0, q_head.word[31:16]} + {4'b0, q_head.word[15:0]} +
				{4'b0, q_head.dport};
		end else if (emit) begin
			case (k_q)
				HW_LEN: begin
					ip_acc_q <= ip_acc_q + {3'b0, tot_len_s1} +
						{3'b0, cfg.source_address[31:16]} + {3'b0, cfg.source_address[15:0]};
					udp_acc_q <= udp_acc_q + {4'b0, cfg.source_address[31:16]} +
						{4'b0, cfg.source_address[15:0]} + {4'b0, cfg.source_port} +
						{12'b0, IPV4_PROTO_UDP};
				end
				HW_IDENT: begin
					ip_acc_q <= {2'b0, {1'b0, ip_acc_q[15:0]} + {14'b0, ip_acc_q[18:16]}};
					udp_acc_q <= udp_acc_q + {3'b0, udp_len_s1, 1'b0};
				end
				HW_PROTO: begin
					udp_acc_q <= {3'b0, {1'b0, udp_acc_q[15:0]} + {13'b0, udp_acc_q[19:16]}};
				end
				HW_SRC: begin
					udp_acc_q <= {4'b0, udp_acc_q[15:0] + {15'b0, udp_acc_q[16]}};
				end
				default: begin
					udp_acc_q <= udp_acc_q;
				end
			endcase
		end
		if (emit) begin
			out_word_q <= word_c;
			out_last_q <= last_c;
			out_nb_q <= nb_c;
			out_port_q <= port_c;
			oversize_q <= over_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_s1 <= 1'b0;
			k_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				job_valid_s1 <= 1'b1;
				k_q <= HW_LEN;
			end else if (job_done) begin
				job_valid_s1 <= 1'b0;
			end else if (emit) begin
				k_q <= k_q + 3'd1;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_word = out_word_q;
	assign out_last = out_last_q;
	assign out_bytes_valid = out_nb_q;
	assign out_port = out_port_q;
	assign oversize = oversize_q;

	a_k_range: assert property (@(posedge clk) disable iff (!arst_n)
		job_valid_s1 && job_s1.cmd == CMD_ENCAP |-> k_q <= HW_UDP)
		else $error("header word index out of range");
	a_decap_no_over: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_port_q == PORT_DECAP |-> !oversize_q)
		else $error("oversize flagged on decap word");
	a_hdr_last: assert property (@(posedge clk) disable iff (!arst_n)
		emit && job_s1.cmd == CMD_ENCAP && k_q == HW_UDP |=> out_valid_q && out_last_q)
		else $error("seventh header word not marked last");
	a_pop_avail: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("job taken from empty queue");

endmodule

@@ rtl/udp_ipv4_tunnel_encap_decap_top.sv @@
// Top level of the UDP/IPv4 tunnel: configuration registers, front end, job queue, back end.
// A result word on out_* passes through the job queue, job register and output register.
// Throughput: one input word per cycle while in_ready is high; the back end emits one word
// per cycle unless out_ready stalls it; the queue absorbs each seven-word encap header.
// in_ready drops only while the job queue (QUEUE_DEPTH entries) is full.
// Reset clears config (UDP checksum on), ID, learned port, payload totals and decap position.
`timescale 1ns / 1ps
module udp_ipv4_tunnel_encap_decap_top #(
	parameter int unsigned QUEUE_DEPTH = udptun_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        command,
	input  logic [31:0] data_word,
	input  logic        last_word,
	input  logic [2:0]  bytes_valid,
	input  logic [31:0] annotated_dest,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] out_word,
	output logic        out_last,
	output logic [2:0]  out_bytes_valid,
	output logic        out_port,
	output logic        oversize
);
	import udptun_pkg::*;

	cfg_t cfg_q;
	logic clr_learn;
	logic q_push;
	job_t q_data;
	logic q_full;
	logic q_pop;
	logic q_empty;
	job_t q_head;

	assign clr_learn = cfg_we && (cfg_index == REG_DEST_PORT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.source_address <= '0;
			cfg_q.dest_address <= '0;
			cfg_q.source_port <= '0;
			cfg_q.dest_port <= '0;
			cfg_q.use_dest_annotation <= 1'b0;
			cfg_q.udp_checksum_enable <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SOURCE_ADDRESS: cfg_q.source_address <= cfg_data;
				REG_DEST_ADDRESS: cfg_q.dest_address <= cfg_data;
				REG_SOURCE_PORT: cfg_q.source_port <= cfg_data[15:0];
				REG_DEST_PORT: cfg_q.dest_port <= cfg_data[15:0];
				REG_USE_DEST_ANNOT: cfg_q.use_dest_annotation <= cfg_data[0];
				REG_UDP_CSUM_EN: cfg_q.udp_checksum_enable <= cfg_data[0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	udptun_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.clr_learn      (clr_learn),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.command        (command),
		.data_word      (data_word),
		.last_word      (last_word),
		.bytes_valid    (bytes_valid),
		.annotated_dest (annotated_dest),
		.q_full         (q_full),
		.q_push         (q_push),
		.q_data         (q_data)
	);

	udptun_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_data),
		.full      (q_full),
		.pop       (q_pop),
		.empty     (q_empty),
		.head      (q_head)
	);

	udptun_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg_q),
		.q_empty         (q_empty),
		.q_head          (q_head),
		.q_pop           (q_pop),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.out_word        (out_word),
		.out_last        (out_last),
		.out_bytes_valid (out_bytes_valid),
		.out_port        (out_port),
		.oversize        (oversize)
	);

endmodule

@@ tb/sv/udp_ipv4_tunnel_encap_decap_checker.sv @@
// Checker for the UDP/IPv4 tunnel block: predicts header and payload words and compares them.
`timescale 1ns / 1ps
module udp_ipv4_tunnel_encap_decap_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic        command,
	input  logic [31:0] data_word,
	input  logic        last_word,
	input  logic [2:0]  bytes_valid,
	input  logic [31:0] annotated_dest,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [31:0] out_word,
	input  logic        out_last,
	input  logic [2:0]  out_bytes_valid,
	input  logic        out_port,
	input  logic        oversize,
	output int          errors,
	output int          pending
);
	import udptun_pkg::*;

	typedef struct packed {
		logic [31:0] word;
		logic        last;
		logic [2:0]  nb;
		logic        port;
		logic        over;
	} tunnel_word_t;

	tunnel_word_t tunnel_words_q[$];
	tunnel_word_t head;
	cfg_t         regs;
	logic [15:0]  ident;
	logic [15:0]  learned_port;
	logic [16:0]  payload_bytes;
	logic [31:0]  payload_sum;
	logic [2:0]   decap_pos;

	function automatic logic [31:0] csum_add(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = a + b;
		return s[31:0] + s[32];
	endfunction

	function automatic logic [31:0] csum_add_word(input logic [31:0] acc, input logic [31:0] w);
		return csum_add(acc, 32'(w[31:16]) + 32'(w[15:0]));
	endfunction

	function automatic logic [15:0] csum_fold(input logic [31:0] s);
		logic [31:0] t;
		t = s[15:0] + s[31:16];
		t = t[15:0] + t[31:16];
		return t[15:0];
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endfunction

	task automatic predict_request(input logic cmd, input logic [31:0] data, input logic lst,
			input logic [2:0] nb_in, input logic [31:0] ann);
		logic [2:0]  nb;
		logic [15:0] dport;
		logic [31:0] w;
		logic [31:0] s;
		logic [31:0] dst;
		logic [17:0] cnt;
		logic [15:0] tot_len;
		logic [15:0] udp_len;
		logic [15:0] c;
		logic        ov;
		logic [31:0] hw [0:6];
		nb = (!lst || nb_in == 3'd0 || nb_in > 3'd4) ? 3'd4 : nb_in;
		dport = (regs.dest_port != 16'd0) ? regs.dest_port : learned_port;
		if (cmd == CMD_DECAP) begin
			if (decap_pos == 3'd5 && regs.dest_port == 16'd0 && learned_port == 16'd0)
				learned_port = data[31:16];
			if (decap_pos == 3'd7)
				tunnel_words_q.push_back('{data, lst, nb, PORT_DECAP, 1'b0});
			if (lst)
				decap_pos = 3'd0;
			else if (decap_pos < 3'd7)
				decap_pos = decap_pos + 3'd1;
		end else begin
			w = data;
			if (nb < 3'd4)
				w &= ~(32'hFFFFFFFF >> (8 * nb));
			payload_sum = csum_add_word(payload_sum, w);
			cnt = payload_bytes + nb;
			payload_bytes = (cnt > BYTE_COUNT_MAX) ? BYTE_COUNT_MAX : cnt[16:0];
			if (lst) begin
				ov = payload_bytes > MAX_PAYLOAD_BYTES;
				tot_len = 16'(payload_bytes + TUNNEL_HDR_BYTES);
				udp_len = 16'(payload_bytes + UDP_HDR_BYTES);
				dst = regs.use_dest_annotation ? ann : regs.dest_address;
				hw[HW_LEN] = {IPV4_VER_IHL_TOS, tot_len};
				hw[HW_IDENT] = {ident, 16'h0000};
				hw[HW_PROTO] = {IPV4_TTL, IPV4_PROTO_UDP, 16'h0000};
				hw[HW_SRC] = regs.source_address;
				hw[HW_DST] = dst;
				s = 32'd0;
				for (int k = 0; k < 5; k++)
					s = csum_add_word(s, hw[k]);
				hw[HW_PROTO][15:0] = ~csum_fold(s);
				hw[HW_PORTS] = {regs.source_port, dport};
				hw[HW_UDP] = {udp_len, 16'h0000};
				if (regs.udp_checksum_enable) begin
					s = payload_sum;
					s = csum_add_word(s, regs.source_address);
					s = csum_add_word(s, dst);
					s = csum_add(s, 32'(IPV4_PROTO_UDP));
					s = csum_add(s, 32'(udp_len));
					s = csum_add_word(s, hw[HW_PORTS]);
					s = csum_add_word(s, hw[HW_UDP]);
					c = ~csum_fold(s);
					if (c == 16'd0)
						c = 16'hFFFF;
					hw[HW_UDP][15:0] = c;
				end
				for (int k = 0; k < 7; k++)
					tunnel_words_q.push_back('{hw[k], k == HW_UDP, 3'd4, PORT_HEADER, ov});
				ident = ident + 16'd1;
				payload_bytes = '0;
				payload_sum = '0;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tunnel_words_q.delete();
			regs = '0;
			regs.udp_checksum_enable = 1'b1;
			ident = '0;
			learned_port = '0;
			payload_bytes = '0;
			payload_sum = '0;
			decap_pos = '0;
			errors = 0;
			pending = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (tunnel_words_q.size() == 0) begin
					$error("unexpected result word %0h on port %0d", out_word, out_port);
					errors++;
				end else begin
					head = tunnel_words_q.pop_front();
					check_field("out_word", head.word, out_word);
					check_field("out_last", 32'(head.last), 32'(out_last));
					check_field("out_bytes_valid", 32'(head.nb), 32'(out_bytes_valid));
					check_field("out_port", 32'(head.port), 32'(out_port));
					check_field("oversize", 32'(head.over), 32'(oversize));
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_SOURCE_ADDRESS: regs.source_address = cfg_data;
					REG_DEST_ADDRESS: regs.dest_address = cfg_data;
					REG_SOURCE_PORT: regs.source_port = cfg_data[15:0];
					REG_DEST_PORT: begin
						regs.dest_port = cfg_data[15:0];
						learned_port = '0;
					end
					REG_USE_DEST_ANNOT: regs.use_dest_annotation = cfg_data[0];
					REG_UDP_CSUM_EN: regs.udp_checksum_enable = cfg_data[0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				predict_request(command, data_word, last_word, bytes_valid, annotated_dest);
			pending = tunnel_words_q.size();
		end
	end

endmodule

@@ tb/sv/udp_ipv4_tunnel_encap_decap_top_tb.sv @@
// Testbench top for the UDP/IPv4 tunnel block: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module udp_ipv4_tunnel_encap_decap_top_tb;
	import udptun_pkg::*;

	localparam int STALL_LIMIT = 3000;
	localparam int HOLD_CYCLES = 300;
	localparam logic [31:0] P2_SRC = 32'hFFFFFFFF;
	localparam logic [15:0] P2_SPORT = 16'hFFFF;
	localparam logic [15:0] P2_DPORT = 16'h0001;
	localparam logic [31:0] ZERO_CSUM_DST = 32'h0A0A0A0A;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = REG_SOURCE_ADDRESS;
	logic [31:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        command = CMD_ENCAP;
	logic [31:0] data_word = '0;
	logic        last_word = 1'b0;
	logic [2:0]  bytes_valid = 3'd4;
	logic [31:0] annotated_dest = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] out_word;
	logic        out_last;
	logic [2:0]  out_bytes_valid;
	logic        out_port;
	logic        oversize;

	int tx_idle_pct = 27;
	int rx_idle_pct = 27;
	bit hold_req = 1'b0;
	bit hold_done = 1'b0;
	int hold_left = 0;
	int stall_cycles = 0;
	int errors;
	int pending;

	udp_ipv4_tunnel_encap_decap_top dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.command(command), .data_word(data_word), .last_word(last_word),
		.bytes_valid(bytes_valid), .annotated_dest(annotated_dest),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_word(out_word), .out_last(out_last), .out_bytes_valid(out_bytes_valid),
		.out_port(out_port), .oversize(oversize)
	);

	udp_ipv4_tunnel_encap_decap_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.command(command), .data_word(data_word), .last_word(last_word),
		.bytes_valid(bytes_valid), .annotated_dest(annotated_dest),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_word(out_word), .out_last(out_last), .out_bytes_valid(out_bytes_valid),
		.out_port(out_port), .oversize(oversize),
		.errors(errors), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver: random stalls, plus one long hold-off to back the block up
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else if (hold_req && !hold_done) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("udp_ipv4_tunnel_encap_decap_top_tb: errors");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// one request per handshake; valid stays up between back-to-back requests
	task automatic send_word(input logic cmd, input logic [31:0] d, input logic lst,
			input logic [2:0] nb, input logic [31:0] ann);
		if ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
		end
		in_valid <= 1'b1;
		command <= cmd;
		data_word <= d;
		last_word <= lst;
		bytes_valid <= nb;
		annotated_dest <= ann;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic send_packet(input logic cmd, input int nwords, input logic [2:0] last_nb);
		logic [2:0] nb;
		for (int i = 0; i < nwords; i++) begin
			if (i == nwords - 1)
				nb = last_nb;
			else
				nb = ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : 3'd4;
			send_word(cmd, $urandom, i == nwords - 1, nb, $urandom);
		end
	endtask

	task automatic write_config(input logic [31:0] src, input logic [31:0] dst,
			input logic [15:0] sport, input logic [15:0] dport, input logic annot,
			input logic csum);
		in_valid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_SOURCE_ADDRESS;
		cfg_data <= src;
		@(posedge clk);
		cfg_index <= REG_DEST_ADDRESS;
		cfg_data <= dst;
		@(posedge clk);
		cfg_index <= REG_SOURCE_PORT;
		cfg_data <= 32'(sport);
		@(posedge clk);
		cfg_index <= REG_DEST_PORT;
		cfg_data <= 32'(dport);
		@(posedge clk);
		cfg_index <= REG_USE_DEST_ANNOT;
		cfg_data <= 32'(annot);
		@(posedge clk);
		cfg_index <= REG_UDP_CSUM_EN;
		cfg_data <= 32'(csum);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic run_traffic(input int n_items, input int encap_pct);
		int   sent;
		int   len;
		logic cmd;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(99) < 10) begin
				send_word(1'($urandom_range(1)), $urandom, 1'($urandom_range(1)),
					3'($urandom_range(7)), $urandom);
				len = 1;
			end else begin
				cmd = ($urandom_range(99) < encap_pct) ? CMD_ENCAP : CMD_DECAP;
				if (cmd == CMD_ENCAP)
					len = $urandom_range(6, 1);
				else if ($urandom_range(4) == 0)
					len = $urandom_range(7, 1);
				else
					len = $urandom_range(14, 8);
				send_packet(cmd, len, ($urandom_range(6) == 0) ? 3'($urandom_range(7))
					: 3'($urandom_range(4, 1)));
			end
			sent += len;
		end
	endtask

	initial begin
		logic [31:0] rest;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// port learning from the first incoming packet
		write_config(32'hC0A80001, 32'h0A000001, 16'h1234, 16'h0000, 1'b0, 1'b1);
		for (int i = 0; i < 8; i++)
			send_word(CMD_DECAP, (i == 5) ? 32'hBEEF0035 : ((i == 7) ? 32'hFFFFFFFF : 32'h0),
				i == 7, (i == 7) ? 3'd2 : 3'd4, 32'h0);
		send_word(CMD_ENCAP, 32'hFFFFFFFF, 1'b1, 3'd1, 32'h0);
		send_word(CMD_ENCAP, 32'h00000000, 1'b0, 3'd4, 32'h0);
		send_word(CMD_ENCAP, 32'hFFFFFFFF, 1'b1, 3'd3, 32'hFFFFFFFF);
		send_word(CMD_ENCAP, 32'h12345678, 1'b1, 3'd0, 32'h0);
		send_word(CMD_ENCAP, 32'h9ABCDEF0, 1'b1, 3'd7, 32'h0);
		send_packet(CMD_DECAP, 7, 3'd4);
		send_word(CMD_DECAP, 32'hA5A5A5A5, 1'b1, 3'd1, 32'h0);

		// annotated destination; last word forces a computed UDP checksum of zero
		write_config(P2_SRC, 32'h00000000, P2_SPORT, P2_DPORT, 1'b1, 1'b1);
		send_word(CMD_ENCAP, 32'h0, 1'b1, 3'd4, 32'hFFFFFFFF);
		send_word(CMD_ENCAP, 32'hFFFFFFFF, 1'b1, 3'd4, 32'h00000000);
		rest = 32'(P2_SRC[31:16]) + 32'(P2_SRC[15:0]) + 32'(ZERO_CSUM_DST[31:16])
			+ 32'(ZERO_CSUM_DST[15:0]) + 32'(IPV4_PROTO_UDP) + 32'(P2_SPORT) + 32'(P2_DPORT)
			+ 2 * (32'(UDP_HDR_BYTES) + 4);
		rest = rest[15:0] + rest[31:16];
		rest = rest[15:0] + rest[31:16];
		send_word(CMD_ENCAP, {16'h0000, ~rest[15:0]}, 1'b1, 3'd4, ZERO_CSUM_DST);

		write_config(32'h0, 32'h0, 16'h0, 16'h0, 1'b0, 1'b0);
		run_traffic(55, 50);

		write_config(32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		run_traffic(55, 50);
		tx_idle_pct = 27;
		rx_idle_pct = 27;

		write_config($urandom, $urandom, 16'($urandom), 16'h0000, 1'b0, 1'b1);
		hold_req = 1'b1;
		run_traffic(55, 90);

		write_config($urandom, $urandom, 16'($urandom), 16'($urandom),
			1'($urandom_range(1)), 1'($urandom_range(1)));
		run_traffic(55, 50);

		in_valid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("udp_ipv4_tunnel_encap_decap_top_tb: clean");
		else
			$display("udp_ipv4_tunnel_encap_decap_top_tb: errors");
		$finish;
	end

endmodule

@@ udp_ipv4_tunnel_encap_decap_top.f @@
rtl/udptun_pkg.sv
rtl/udptun_front.sv
rtl/udptun_queue.sv
rtl/udptun_back.sv
rtl/udp_ipv4_tunnel_encap_decap_top.sv
tb/sv/udp_ipv4_tunnel_encap_decap_checker.sv
tb/sv/udp_ipv4_tunnel_encap_decap_top_tb.sv
